>>> design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int ELEM_W      = 16;
  localparam int NUM_W       = ELEM_W + 1;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [ELEM_W-1:0] e00;
    logic signed [ELEM_W-1:0] e01;
    logic signed [ELEM_W-1:0] e02;
    logic signed [ELEM_W-1:0] e10;
    logic signed [ELEM_W-1:0] e11;
    logic signed [ELEM_W-1:0] e12;
    logic signed [ELEM_W-1:0] e20;
    logic signed [ELEM_W-1:0] e21;
    logic signed [ELEM_W-1:0] e22;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] qi;
    logic signed [ELEM_W-1:0] qj;
    logic signed [ELEM_W-1:0] qk;
    logic signed [ELEM_W-1:0] qw;
    logic                     degenerate;
  } out_t;

  // component that carries the root itself
  typedef enum logic [1:0] {
    SEL_I = 2'd0,
    SEL_J = 2'd1,
    SEL_K = 2'd2,
    SEL_W = 2'd3
  } sel_e;

  typedef struct packed {
    sel_e sel;
    logic deg;
  } cls_t;

  typedef logic signed [NUM_W-1:0] num_t;

  typedef struct packed {
    num_t n0;
    num_t n1;
    num_t n2;
  } nums_t;

endpackage

>>> design/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Rotation matrix (Q2.14) to unit quaternion (Q1.14), fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; the root and divider pipelines take a new
// word every cycle and advance together whenever the output register is free.
// Reset clears all valid flags and queue pointers at once; no clearing pass.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rmq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rmq_pkg::out_t out_o
);
  import rmq_pkg::*;

  localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int QDW = $bits(cls_t) + $bits(nums_t) + RW;

  logic          f_valid, q_full, q_valid, q_pop;
  cls_t          f_cls, b_cls;
  nums_t         f_nums, b_nums;
  logic [RW-1:0] f_rad, b_rad;
  logic [QDW-1:0] q_rdata;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .fwd_valid_o(f_valid), .fwd_full_i(q_full),
    .cls_o(f_cls), .nums_o(f_nums), .rad_o(f_rad)
  );

  rmq_queue #(.W(QDW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .wdata_i({f_cls, f_nums, f_rad}),
    .full_o(q_full), .pop_i(q_pop), .valid_o(q_valid), .rdata_o(q_rdata)
  );

  assign {b_cls, b_nums, b_rad} = q_rdata;

  rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .in_valid_i(q_valid), .pop_o(q_pop),
    .in_cls_i(b_cls), .in_nums_i(b_nums), .in_rad_i(b_rad),
    .out_valid_o, .out_stall_i, .out_o
  );

endmodule

>>> design/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int XW  = 32,
  parameter int SBW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [XW-1:0]       x_i,
  input  logic [SBW-1:0]      sb_i,
  output logic                valid_o,
  output logic [XW/2-1:0]     root_o,
  output logic [SBW-1:0]      sb_o
);

  localparam int RTW = XW / 2;
  localparam int RMW = RTW + 3;

  logic [RTW-1:0] vld_q;
  logic [RMW-1:0] rem_q  [RTW];
  logic [RMW-1:0] rem_d  [RTW];
  logic [RTW-1:0] root_q [RTW];
  logic [RTW-1:0] root_d [RTW];
  logic [XW-1:0]  x_q    [RTW];
  logic [XW-1:0]  x_d    [RTW];
  logic [SBW-1:0] sb_q   [RTW];

  always_comb begin
    logic [RMW-1:0] rin;
    logic [RTW-1:0] oin;
    logic [XW-1:0]  xin;
    logic [RMW-1:0] cur;
    logic [RMW-1:0] trial;
    logic           fit;
    for (int i = 0; i < RTW; i++) begin
      if (i == 0) begin
        rin = '0;
        oin = '0;
        xin = x_i;
      end else begin
        rin = rem_q[(i == 0) ? 0 : i-1];
        oin = root_q[(i == 0) ? 0 : i-1];
        xin = x_q[(i == 0) ? 0 : i-1];
      end
      cur       = {rin[RMW-3:0], xin[XW-1 -: 2]};
      trial     = RMW'({oin, 2'b01});
      fit       = (cur >= trial);
      rem_d[i]  = fit ? (cur - trial) : cur;
      root_d[i] = {oin[RTW-2:0], fit};
      x_d[i]    = {xin[XW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RTW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_i;
      for (int i = 0; i < RTW; i++) begin
        rem_q[i]  <= rem_d[i];
        root_q[i] <= root_d[i];
        x_q[i]    <= x_d[i];
        if (i > 0) sb_q[i] <= sb_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign valid_o = vld_q[RTW-1];
  assign root_o  = root_q[RTW-1];
  assign sb_o    = sb_q[RTW-1];

endmodule

>>> design/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The quotient must fit in QW bits (num >> QW is below the divisor).
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int NW  = 32,
  parameter int DW  = 16,
  parameter int QW  = 16,
  parameter int SBW = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DW-1:0]  den_i,
  input  logic [SBW-1:0] sb_i,
  output logic           valid_o,
  output logic [QW-1:0]  quo_o,
  output logic [SBW-1:0] sb_o
);

  localparam int RMW = DW + 1;

  logic [QW-1:0]  vld_q;
  logic [RMW-1:0] rem_q [QW];
  logic [RMW-1:0] rem_d [QW];
  logic [QW-1:0]  quo_q [QW];
  logic [QW-1:0]  quo_d [QW];
  logic [QW-1:0]  lo_q  [QW];
  logic [QW-1:0]  lo_d  [QW];
  logic [DW-1:0]  den_q [QW];
  logic [DW-1:0]  den_d [QW];
  logic [SBW-1:0] sb_q  [QW];

  always_comb begin
    logic [RMW-1:0] rin;
    logic [QW-1:0]  qin;
    logic [QW-1:0]  lin;
    logic [DW-1:0]  din;
    logic [RMW-1:0] t;
    logic           fit;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        rin = RMW'(num_i >> QW);
        qin = '0;
        lin = num_i[QW-1:0];
        din = den_i;
      end else begin
        rin = rem_q[(i == 0) ? 0 : i-1];
        qin = quo_q[(i == 0) ? 0 : i-1];
        lin = lo_q[(i == 0) ? 0 : i-1];
        din = den_q[(i == 0) ? 0 : i-1];
      end
      t        = {rin[DW-1:0], lin[QW-1]};
      fit      = (t >= {1'b0, din});
      rem_d[i] = fit ? (t - {1'b0, din}) : t;
      quo_d[i] = {qin[QW-2:0], fit};
      lo_d[i]  = {lin[QW-2:0], 1'b0};
      den_d[i] = din;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q[0] <= sb_i;
      for (int i = 0; i < QW; i++) begin
        rem_q[i] <= rem_d[i];
        quo_q[i] <= quo_d[i];
        lo_q[i]  <= lo_d[i];
        den_q[i] <= den_d[i];
        if (i > 0) sb_q[i] <= sb_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign sb_o    = sb_q[QW-1];

endmodule

>>> design/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Takes a matrix word, picks the branch, forms radicand and numerators.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int FRAC_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rmq_pkg::in_t        in_i,
  output logic                fwd_valid_o,
  input  logic                fwd_full_i,
  output rmq_pkg::cls_t       cls_o,
  output rmq_pkg::nums_t      nums_o,
  output logic [((FRAC_BITS > 17) ? FRAC_BITS : 17):0] rad_o
);
  import rmq_pkg::*;

  localparam int RW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int RSW = RW + 1;
  localparam logic signed [RSW-1:0] ONE = RSW'(1) << FRAC_BITS;

  logic signed [RSW-1:0] a00, a11, a22, tr, r;
  cls_t  cls;
  nums_t nums;
  logic  accept, moved;

  logic          valid_q;
  cls_t          cls_q;
  nums_t         nums_q;
  logic [RW-1:0] rad_q;

  assign a00 = RSW'(in_i.e00);
  assign a11 = RSW'(in_i.e11);
  assign a22 = RSW'(in_i.e22);
  assign tr  = a00 + a11 + a22;

  always_comb begin
    if (!tr[RSW-1] && (tr != '0)) begin
      cls.sel = SEL_W;
      r       = ONE + tr;
      nums.n0 = NUM_W'(in_i.e12) - NUM_W'(in_i.e21);
      nums.n1 = NUM_W'(in_i.e20) - NUM_W'(in_i.e02);
      nums.n2 = NUM_W'(in_i.e01) - NUM_W'(in_i.e10);
    end else if ((in_i.e00 > in_i.e11) && (in_i.e00 > in_i.e22)) begin
      cls.sel = SEL_I;
      r       = ONE + a00 - a11 - a22;
      nums.n0 = NUM_W'(in_i.e10) + NUM_W'(in_i.e01);
      nums.n1 = NUM_W'(in_i.e20) + NUM_W'(in_i.e02);
      nums.n2 = NUM_W'(in_i.e12) - NUM_W'(in_i.e21);
    end else if (in_i.e11 > in_i.e22) begin
      cls.sel = SEL_J;
      r       = ONE + a11 - a00 - a22;
      nums.n0 = NUM_W'(in_i.e10) + NUM_W'(in_i.e01);
      nums.n1 = NUM_W'(in_i.e21) + NUM_W'(in_i.e12);
      nums.n2 = NUM_W'(in_i.e20) - NUM_W'(in_i.e02);
    end else begin
      cls.sel = SEL_K;
      r       = ONE + a22 - a00 - a11;
      nums.n0 = NUM_W'(in_i.e20) + NUM_W'(in_i.e02);
      nums.n1 = NUM_W'(in_i.e21) + NUM_W'(in_i.e12);
      nums.n2 = NUM_W'(in_i.e01) - NUM_W'(in_i.e10);
    end
    cls.deg = r[RSW-1] || (r == '0);
  end

  assign in_stall_o = valid_q && fwd_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign moved      = valid_q && !fwd_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (moved) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q  <= cls;
      nums_q <= nums;
      rad_q  <= r[RW-1:0];
    end
  end

  assign fwd_valid_o = valid_q;
  assign cls_o       = cls_q;
  assign nums_o      = nums_q;
  assign rad_o       = rad_q;

endmodule

>>> design/rmq_queue.sv
// ----------------------------------------------------------------------------
// rmq_queue
// Small register queue between the front and the back.
// ----------------------------------------------------------------------------
module rmq_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] rdata_o
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

endmodule

>>> design/rmq_back.sv
// ----------------------------------------------------------------------------
// rmq_back
// Root, scale division, length and normalization pipeline with output register.
// ----------------------------------------------------------------------------
module rmq_back #(
  parameter int FRAC_BITS = 14
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                pop_o,
  input  rmq_pkg::cls_t       in_cls_i,
  input  rmq_pkg::nums_t      in_nums_i,
  input  logic [((FRAC_BITS > 17) ? FRAC_BITS : 17):0] in_rad_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rmq_pkg::out_t       out_o
);
  import rmq_pkg::*;

  localparam int RW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
  localparam int XW1   = RW + FRAC_BITS + ((RW + FRAC_BITS) % 2);
  localparam int RTW1  = XW1 / 2;
  localparam int QB    = 16 + (FRAC_BITS + 1) / 2;
  localparam int DNW1  = NUM_W + FRAC_BITS;
  localparam int CLSW  = $bits(cls_t);
  localparam int NUMSW = $bits(nums_t);
  localparam int SB1W  = CLSW + NUMSW;
  localparam int SBD0W = 2 + 1 + RTW1 + 1;
  localparam int XW2   = 2 * QB + 2;
  localparam int LW    = QB + 1;
  localparam int SB2W  = 1 + 4 + 4 * QB;
  localparam int DNW2  = QB + FRAC_BITS;
  localparam int QW2   = FRAC_BITS + 1;
  localparam logic signed [32:0] SAT_HI = 33'sd32767;
  localparam logic signed [32:0] SAT_LO = -33'sd32768;

  logic adv;
  logic out_valid_q;
  out_t out_q;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = adv && in_valid_i;

  // radicand root
  logic [XW1-1:0]  x1;
  logic            v1;
  logic [RTW1-1:0] root1;
  logic [SB1W-1:0] sb1;
  cls_t            cls1;
  nums_t           nums1;

  assign x1 = XW1'(in_rad_i) << FRAC_BITS;

  rmq_sqrt #(.XW(XW1), .SBW(SB1W)) u_root (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(in_valid_i), .x_i(x1),
    .sb_i({in_cls_i, in_nums_i}), .valid_o(v1), .root_o(root1), .sb_o(sb1)
  );

  assign cls1  = cls_t'(sb1[SB1W-1 -: CLSW]);
  assign nums1 = nums_t'(sb1[NUMSW-1:0]);

  // numerators over scale 2*root
  logic [RTW1:0]    scale1;
  logic [RTW1-1:0]  big1;
  logic             deg1;
  num_t             nv [3];
  logic [NUM_W-1:0] nmag [3];
  logic [DNW1-1:0]  dnum [3];

  assign scale1 = {root1, 1'b0};
  assign big1   = root1 >> 1;
  assign deg1   = cls1.deg || (root1 == '0);
  assign nv[0]  = nums1.n0;
  assign nv[1]  = nums1.n1;
  assign nv[2]  = nums1.n2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nmag[k] = nv[k][NUM_W-1] ? NUM_W'(-nv[k]) : NUM_W'(nv[k]);
      dnum[k] = DNW1'(nmag[k]) << FRAC_BITS;
    end
  end

  logic             v2;
  logic [QB-1:0]    quo1 [3];
  logic [SBD0W-1:0] sbd0;
  logic             sgn1, sgn2;

  rmq_div #(.NW(DNW1), .DW(RTW1+1), .QW(QB), .SBW(SBD0W)) u_div_n0 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v1), .num_i(dnum[0]), .den_i(scale1),
    .sb_i({cls1.sel, deg1, big1, nv[0][NUM_W-1]}),
    .valid_o(v2), .quo_o(quo1[0]), .sb_o(sbd0)
  );

  rmq_div #(.NW(DNW1), .DW(RTW1+1), .QW(QB), .SBW(1)) u_div_n1 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v1), .num_i(dnum[1]), .den_i(scale1),
    .sb_i(nv[1][NUM_W-1]), .valid_o(), .quo_o(quo1[1]), .sb_o(sgn1)
  );

  rmq_div #(.NW(DNW1), .DW(RTW1+1), .QW(QB), .SBW(1)) u_div_n2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v1), .num_i(dnum[2]), .den_i(scale1),
    .sb_i(nv[2][NUM_W-1]), .valid_o(), .quo_o(quo1[2]), .sb_o(sgn2)
  );

  sel_e            sel2;
  logic            deg2;
  logic [RTW1-1:0] big2;
  logic            sgn0;
  logic [QB-1:0]   pm [4];
  logic [3:0]      ps;

  assign sel2 = sel_e'(sbd0[SBD0W-1 -: 2]);
  assign deg2 = sbd0[SBD0W-3];
  assign big2 = sbd0[RTW1:1];
  assign sgn0 = sbd0[0];

  // put the root component in its slot, quotients fill the rest in order
  always_comb begin
    case (sel2)
      SEL_I: begin
        pm[0] = QB'(big2); pm[1] = quo1[0]; pm[2] = quo1[1]; pm[3] = quo1[2];
        ps    = {sgn2, sgn1, sgn0, 1'b0};
      end
      SEL_J: begin
        pm[0] = quo1[0]; pm[1] = QB'(big2); pm[2] = quo1[1]; pm[3] = quo1[2];
        ps    = {sgn2, sgn1, 1'b0, sgn0};
      end
      SEL_K: begin
        pm[0] = quo1[0]; pm[1] = quo1[1]; pm[2] = QB'(big2); pm[3] = quo1[2];
        ps    = {sgn2, 1'b0, sgn1, sgn0};
      end
      default: begin
        pm[0] = quo1[0]; pm[1] = quo1[1]; pm[2] = quo1[2]; pm[3] = QB'(big2);
        ps    = {1'b0, sgn2, sgn1, sgn0};
      end
    endcase
  end

  // placement, squares, sum of squares
  logic              a_valid_q, b_valid_q, c_valid_q;
  logic              a_deg_q, b_deg_q, c_deg_q;
  logic [QB-1:0]     a_mag_q [4];
  logic [QB-1:0]     b_mag_q [4];
  logic [QB-1:0]     c_mag_q [4];
  logic [3:0]        a_sgn_q, b_sgn_q, c_sgn_q;
  logic [2*QB-1:0]   b_sq_q [4];
  logic [XW2-1:0]    c_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= v2;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_deg_q <= deg2;
      a_sgn_q <= ps;
      b_deg_q <= a_deg_q;
      b_sgn_q <= a_sgn_q;
      c_deg_q <= b_deg_q;
      c_sgn_q <= b_sgn_q;
      for (int a = 0; a < 4; a++) begin
        a_mag_q[a] <= pm[a];
        b_mag_q[a] <= a_mag_q[a];
        b_sq_q[a]  <= a_mag_q[a] * a_mag_q[a];
        c_mag_q[a] <= b_mag_q[a];
      end
      c_sum_q <= XW2'(b_sq_q[0]) + XW2'(b_sq_q[1]) + XW2'(b_sq_q[2]) + XW2'(b_sq_q[3]);
    end
  end

  // length
  logic            v3;
  logic [LW-1:0]   len3;
  logic [SB2W-1:0] sb3;
  logic            deg3;
  logic [3:0]      sgn3;
  logic [DNW2-1:0] dnum2 [4];

  rmq_sqrt #(.XW(XW2), .SBW(SB2W)) u_len (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(c_valid_q), .x_i(c_sum_q),
    .sb_i({c_deg_q, c_sgn_q, c_mag_q[3], c_mag_q[2], c_mag_q[1], c_mag_q[0]}),
    .valid_o(v3), .root_o(len3), .sb_o(sb3)
  );

  assign deg3 = sb3[SB2W-1] || (len3 == '0);
  assign sgn3 = sb3[SB2W-2 -: 4];

  always_comb begin
    for (int a = 0; a < 4; a++) begin
      dnum2[a] = DNW2'(sb3[a*QB +: QB]) << FRAC_BITS;
    end
  end

  // normalization
  logic           v4;
  logic           deg4;
  logic [3:0]     sgn4;
  logic [QW2-1:0] quo2 [4];

  rmq_div #(.NW(DNW2), .DW(LW), .QW(QW2), .SBW(2)) u_norm0 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v3), .num_i(dnum2[0]), .den_i(len3),
    .sb_i({deg3, sgn3[0]}), .valid_o(v4), .quo_o(quo2[0]), .sb_o({deg4, sgn4[0]})
  );

  rmq_div #(.NW(DNW2), .DW(LW), .QW(QW2), .SBW(1)) u_norm1 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v3), .num_i(dnum2[1]), .den_i(len3),
    .sb_i(sgn3[1]), .valid_o(), .quo_o(quo2[1]), .sb_o(sgn4[1])
  );

  rmq_div #(.NW(DNW2), .DW(LW), .QW(QW2), .SBW(1)) u_norm2 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v3), .num_i(dnum2[2]), .den_i(len3),
    .sb_i(sgn3[2]), .valid_o(), .quo_o(quo2[2]), .sb_o(sgn4[2])
  );

  rmq_div #(.NW(DNW2), .DW(LW), .QW(QW2), .SBW(1)) u_norm3 (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(v3), .num_i(dnum2[3]), .den_i(len3),
    .sb_i(sgn3[3]), .valid_o(), .quo_o(quo2[3]), .sb_o(sgn4[3])
  );

  // sign, clamp to 16 bits; quotient never exceeds one since |q| <= len
  logic [ELEM_W-1:0] res [4];

  always_comb begin
    logic signed [32:0] v;
    for (int a = 0; a < 4; a++) begin
      v = 33'(quo2[a]);
      if (sgn4[a]) v = -v;
      if (v > SAT_HI) v = SAT_HI;
      if (v < SAT_LO) v = SAT_LO;
      res[a] = deg4 ? '0 : v[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v4;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.qi         <= res[0];
      out_q.qj         <= res[1];
      out_q.qk         <= res[2];
      out_q.qw         <= res[3];
      out_q.degenerate <= deg4;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> design/rmq_chk.sv
// ----------------------------------------------------------------------------
// rmq_chk
// Port-level checks for the quaternion converter, bound to the top level.
// ----------------------------------------------------------------------------
module rmq_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input rmq_pkg::in_t  in_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input rmq_pkg::out_t out_o
);
  import rmq_pkg::*;

  logic [31:0] pend_q;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 32'(in_acc) - 32'(out_acc);
    end
  end

  // output valid may still be unknown at the very first edge of reset
  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled output word changed");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (pend_q != '0))
    else $error("output word without a pending input");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.degenerate |->
      (out_o.qi == '0) && (out_o.qj == '0) && (out_o.qk == '0) && (out_o.qw == '0))
    else $error("degenerate word with nonzero components");

endmodule

bind rotation_matrix_to_quaternion rmq_chk u_rmq_chk (.*);
